FILE: rtl/psnr_pkg.sv
`default_nettype none

package psnr_pkg;

  // store geometry and coordinate width
  localparam int STORE_DEPTH = 64;
  localparam int COORD_BITS  = 16;

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CNTW = $clog2(STORE_DEPTH + 1);

  // field widths on the ports
  localparam int IN_COORD_W  = 16;
  localparam int RADIUS_W    = 15;
  localparam int INDEX_W     = 6;
  localparam int BOX_W       = 16;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  // distance datapath widths
  localparam int MAGW = COORD_BITS + 1;
  localparam int SQW  = 2 * MAGW;
  localparam int DW   = SQW + 2;
  localparam int R2W  = 2 * RADIUS_W;
  localparam int CMPW = (DW > R2W) ? DW : R2W;

  localparam int PT_W = 3 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_NEAREST = 2'd1,
    OP_RADIUS  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  // tag that travels beside a point through the distance pipeline
  typedef struct packed {
    logic          vld;
    logic [AW-1:0] idx;
  } tag_t;

  // sign-extend a port coordinate and clamp it to the stored range
  function automatic coord_t sat_coord(input logic [IN_COORD_W-1:0] raw);
    logic signed [21:0] v;
    logic signed [21:0] hi;
    logic signed [21:0] lo;
    v  = 22'($signed(raw));
    hi = 22'((1 << (COORD_BITS - 1)) - 1);
    lo = -hi - 22'sd1;
    if (COORD_BITS < IN_COORD_W) begin
      if (v > hi) v = hi;
      if (v < lo) v = lo;
    end
    return v[COORD_BITS-1:0];
  endfunction

  // stored coordinate back to the 16 bit port form
  function automatic logic [BOX_W-1:0] box_word(input coord_t c);
    logic signed [21:0] w;
    w = 22'(c);
    return w[BOX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/psnr_ram.sv
`default_nettype none

module psnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/psnr_dist.sv
`default_nettype none

module psnr_dist import psnr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire tag_t            tag_i,
  input  wire logic [PT_W-1:0] point_i,
  input  wire logic [PT_W-1:0] query_i,
  output tag_t                 tag_o,
  output logic [DW-1:0]        dist_o
);

  logic signed [MAGW-1:0] diff_w [3];
  logic [MAGW-1:0]        mag_d  [3];
  logic [MAGW-1:0]        mag_q  [3];
  logic [SQW-1:0]         sq_d   [3];
  logic [SQW-1:0]         sq_q   [3];
  logic [DW-1:0]          dist_d;
  logic [DW-1:0]          dist_q;
  tag_t                   tag_a_q, tag_b_q, tag_c_q;

  // absolute differences per axis, their squares and the sum of squares
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_w[k] = MAGW'($signed(point_i[k*COORD_BITS +: COORD_BITS]))
                - MAGW'($signed(query_i[k*COORD_BITS +: COORD_BITS]));
      mag_d[k]  = diff_w[k][MAGW-1] ? MAGW'(-diff_w[k]) : MAGW'(diff_w[k]);
      sq_d[k]   = SQW'(mag_q[k]) * SQW'(mag_q[k]);
    end
    dist_d = DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else if (en_i) begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= mag_d[k];
        sq_q[k]  <= sq_d[k];
      end
      dist_q <= dist_d;
    end
  end

  assign tag_o  = tag_c_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

FILE: rtl/point_store_nearest_and_radius_search_top.sv
// add, or a query on an empty store: S_FIN loads the result word once the output is free
// nearest and radius over n stored points: the scan reads one stored point per cycle
// unless stalled, through the ram port and a 3 stage distance pipeline to the final word
// input is taken again from the cycle after the final word is loaded; a radius match
// while one is held back and the output register is full holds the scan until it drains
// reset clears point count, bounding box and handshake state; the store needs no clearing
`default_nettype none

module point_store_nearest_and_radius_search_top import psnr_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input words
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // x_coord, y_coord, z_coord, search_radius, one pad bit
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // opcode
  input  wire logic [1:0]             s_axis_tuser_i,
  // result words
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // point_index, box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z, pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // status
  output logic [1:0]                  m_axis_tuser_o,
  // last_flag
  output logic                        m_axis_tlast_o
);

  // ---------------------------------------------------------------------------
  // state and registers
  // ---------------------------------------------------------------------------
  state_e          state_q, state_d;

  logic [CNTW-1:0] count_q;
  coord_t          box_min_q [3];
  coord_t          box_max_q [3];

  // query context latched at acceptance
  op_e             op_q;
  logic [PT_W-1:0] query_q;
  logic [R2W-1:0]  r2_q;

  // fixed result for add and empty-store queries
  logic            fixed_q;
  status_e         res_status_q;
  logic [AW-1:0]   res_idx_q;

  // scan bookkeeping
  logic [CNTW-1:0] iss_q;
  tag_t            tag_rd_q;
  logic [DW-1:0]   best_q;
  logic [AW-1:0]   best_idx_q;
  logic            pend_vld_q;
  logic [AW-1:0]   pend_idx_q;

  // output register
  logic            out_vld_q;
  status_e         out_status_q;
  logic [AW-1:0]   out_idx_q;
  logic            out_last_q;
  logic [BOX_W-1:0] out_box_q [6];

  // ---------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------
  logic            in_acc;
  op_e             in_op;
  coord_t          in_c [3];
  logic [RADIUS_W-1:0] in_rad;
  logic            store_full;
  logic            store_empty;

  assign in_op  = op_e'(s_axis_tuser_i);
  assign in_c[0] = sat_coord(s_axis_tdata_i[15:0]);
  assign in_c[1] = sat_coord(s_axis_tdata_i[31:16]);
  assign in_c[2] = sat_coord(s_axis_tdata_i[47:32]);
  assign in_rad = s_axis_tdata_i[62:48];
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign store_full  = (count_q == CNTW'(STORE_DEPTH));
  assign store_empty = (count_q == '0);

  // ---------------------------------------------------------------------------
  // point store and distance pipeline
  // ---------------------------------------------------------------------------
  logic            ram_we;
  logic [PT_W-1:0] ram_rdata;
  logic            issue;
  logic            adv;
  tag_t            tag_ev;
  logic [DW-1:0]   dist_ev;

  assign ram_we = in_acc && (in_op == OP_ADD) && !store_full;

  psnr_ram #(
    .WIDTH (PT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({in_c[2], in_c[1], in_c[0]}),
    .re_i    (issue),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  psnr_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .tag_i   (tag_rd_q),
    .point_i (ram_rdata),
    .query_i (query_q),
    .tag_o   (tag_ev),
    .dist_o  (dist_ev)
  );

  // ---------------------------------------------------------------------------
  // evaluation and control outputs
  // ---------------------------------------------------------------------------
  logic            out_free;
  logic            match;
  logic            closer;
  logic            stall;
  logic            scan_end;
  logic            emit_mid;
  logic            emit_fin;
  status_e         fin_status;
  logic [AW-1:0]   fin_idx;
  logic            load;
  status_e         load_status;
  logic [AW-1:0]   load_idx;
  logic            load_last;

  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    out_free = !out_vld_q || m_axis_tready_i;
    match    = tag_ev.vld && (op_q == OP_RADIUS) && (CMPW'(dist_ev) < CMPW'(r2_q));
    closer   = (tag_ev.idx == '0) || (dist_ev < best_q);
    // a second match needs the output register to hand on the one held back
    stall    = match && pend_vld_q && !out_free;
    adv      = !stall;
    issue    = (state_q == S_SCAN) && adv && (iss_q < count_q);
    scan_end = (state_q == S_SCAN) && adv && tag_ev.vld
            && (CNTW'(tag_ev.idx) == (count_q - CNTW'(1)));
    emit_mid = match && pend_vld_q && adv;
    emit_fin = (state_q == S_FIN) && out_free;

    if (fixed_q) begin
      fin_status = res_status_q;
      fin_idx    = res_idx_q;
    end else if (op_q == OP_NEAREST) begin
      fin_status = STAT_OK;
      fin_idx    = best_idx_q;
    end else if (pend_vld_q) begin
      fin_status = STAT_OK;
      fin_idx    = pend_idx_q;
    end else begin
      fin_status = STAT_NONE;
      fin_idx    = '0;
    end

    load = emit_mid || emit_fin;
    if (emit_mid) begin
      load_status = STAT_OK;
      load_idx    = pend_idx_q;
      load_last   = 1'b0;
    end else begin
      load_status = fin_status;
      load_idx    = fin_idx;
      load_last   = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_ADD:     state_d = S_FIN;
            OP_NEAREST: state_d = store_empty ? S_FIN : S_SCAN;
            OP_RADIUS:  state_d = store_empty ? S_FIN : S_SCAN;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      iss_q      <= '0;
      tag_rd_q   <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        box_min_q[k] <= '0;
        box_max_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (ram_we) begin
        count_q <= count_q + CNTW'(1);
        for (int k = 0; k < 3; k++) begin
          if (in_c[k] < box_min_q[k]) box_min_q[k] <= in_c[k];
          if (in_c[k] > box_max_q[k]) box_max_q[k] <= in_c[k];
        end
      end

      if (in_acc) begin
        iss_q      <= '0;
        pend_vld_q <= 1'b0;
      end else begin
        if (issue) iss_q <= iss_q + CNTW'(1);
        if (match && adv) pend_vld_q <= 1'b1;
      end

      // read tag lines up with the registered ram data
      if (adv) begin
        tag_rd_q.vld <= issue;
        tag_rd_q.idx <= iss_q[AW-1:0];
      end

      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_op;
      query_q <= {in_c[2], in_c[1], in_c[0]};
      r2_q    <= R2W'(in_rad) * R2W'(in_rad);
      fixed_q <= (in_op == OP_ADD) || store_empty;
      if (in_op == OP_ADD) begin
        res_status_q <= store_full ? STAT_FULL : STAT_OK;
        res_idx_q    <= store_full ? '0 : count_q[AW-1:0];
      end else begin
        res_status_q <= STAT_NONE;
        res_idx_q    <= '0;
      end
    end

    // nearest keeps the lowest index on a tie
    if (tag_ev.vld && (op_q == OP_NEAREST) && closer) begin
      best_q     <= dist_ev;
      best_idx_q <= tag_ev.idx;
    end

    if (match && adv) begin
      pend_idx_q <= tag_ev.idx;
    end

    // box snapshot goes with each word
    if (load) begin
      out_status_q <= load_status;
      out_idx_q    <= load_idx;
      out_last_q   <= load_last;
      out_box_q[0] <= box_word(box_min_q[0]);
      out_box_q[1] <= box_word(box_max_q[0]);
      out_box_q[2] <= box_word(box_min_q[1]);
      out_box_q[3] <= box_word(box_max_q[1]);
      out_box_q[4] <= box_word(box_min_q[2]);
      out_box_q[5] <= box_word(box_max_q[2]);
    end
  end

  // ---------------------------------------------------------------------------
  // output port
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b00, out_box_q[5], out_box_q[4], out_box_q[3],
                            out_box_q[2], out_box_q[1], out_box_q[0],
                            INDEX_W'(out_idx_q)};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(STORE_DEPTH))
    else $error("point count beyond store depth");

  a_stall_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> (state_q == S_SCAN) && pend_vld_q)
    else $error("pipeline held outside a radius scan");

  a_mid_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_mid |=> out_vld_q && !out_last_q)
    else $error("radius match word marked last");

  a_eval_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_ev.vld |-> (state_q == S_SCAN) && (CNTW'(tag_ev.idx) < count_q))
    else $error("evaluated entry not below point count");

endmodule

`default_nettype wire
